[hdl/crc32rb_pkg.sv]
package crc32rb_pkg;

   localparam int unsigned CRC_WIDTH  = 32;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned ADDR_WIDTH = 4;

   localparam logic [CRC_WIDTH-1:0] POLY_RESET    = 32'h04C1_1DB7;
   localparam logic [CRC_WIDTH-1:0] INIT_RESET    = 32'hFFFF_FFFF;
   localparam logic [CRC_WIDTH-1:0] XOR_OUT_RESET = 32'hFFFF_FFFF;

   // Register index, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_POLY    = 2'd0,
      REG_INIT    = 2'd1,
      REG_XOR_OUT = 2'd2
   } creg_type;

   typedef logic [CRC_WIDTH-1:0]  crc_type;
   typedef logic [BYTE_WIDTH-1:0] byte_type;

endpackage

[hdl/crc32_reflected_byte_engine.sv]
// A request goes first into the input register, then into the result register on rsp_.
// Throughput: one byte per cycle while rsp_tready holds no result back; the running CRC
// is folded through an eight-step shift/xor chain between the two registers.
// Reset (synchronous, active high): both stages empty, running CRC zero,
// polynomial 0x04C11DB7, init and xor-out values all ones.
module crc32_reflected_byte_engine (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] data_byte, [39:8] seed
   input  logic        req_tuser,   // [0] first_byte
   input  logic        req_tlast,   // last_byte
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] crc_value
   output logic        rsp_tlast,   // end_of_message
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers.
   crc32rb_pkg::crc_type poly_ff, poly_in;
   crc32rb_pkg::crc_type init_ff, init_in;
   crc32rb_pkg::crc_type xor_out_ff, xor_out_in;

   // Input stage.
   logic                  in_valid_ff, in_valid_in;
   crc32rb_pkg::byte_type in_byte_ff, in_byte_in;
   crc32rb_pkg::crc_type  in_seed_ff, in_seed_in;
   logic                  in_first_ff, in_first_in;
   logic                  in_last_ff, in_last_in;

   // Result stage and running state.
   logic                 rsp_valid_ff, rsp_valid_in;
   crc32rb_pkg::crc_type rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   crc32rb_pkg::crc_type running_crc_ff, running_crc_in;

   logic                 advance;
   logic                 csr_write;
   logic [1:0]           csr_index;
   crc32rb_pkg::crc_type rpoly;
   crc32rb_pkg::crc_type crc_next;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      poly_in    = poly_ff;
      init_in    = init_ff;
      xor_out_in = xor_out_ff;
      csr_prdata = '0;
      case (csr_index)
         crc32rb_pkg::REG_POLY: begin
            csr_prdata = poly_ff;
            if (csr_write) begin
               poly_in = csr_pwdata;
            end
         end
         crc32rb_pkg::REG_INIT: begin
            csr_prdata = init_ff;
            if (csr_write) begin
               init_in = csr_pwdata;
            end
         end
         crc32rb_pkg::REG_XOR_OUT: begin
            csr_prdata = xor_out_ff;
            if (csr_write) begin
               xor_out_in = csr_pwdata;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // The input stage moves on when the result register is free or being emptied.
   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_seed_in  = in_seed_ff;
      in_first_in = in_first_ff;
      in_last_in  = in_last_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata[7:0];
         in_seed_in  = req_tdata[39:8];
         in_first_in = req_tuser;
         in_last_in  = req_tlast;
      end
   end

   // Reflected polynomial is just the normal form with its bits reversed.
   always_comb begin
      for (int k = 0; k < crc32rb_pkg::CRC_WIDTH; k++) begin
         rpoly[k] = poly_ff[crc32rb_pkg::CRC_WIDTH-1-k];
      end
   end

   // Eight LSB-first shift/xor steps fold one byte into the CRC.
   always_comb begin
      crc32rb_pkg::crc_type crc;
      crc = in_first_ff ? (in_seed_ff ^ init_ff) : running_crc_ff;
      crc = crc ^ {{(crc32rb_pkg::CRC_WIDTH-crc32rb_pkg::BYTE_WIDTH){1'b0}}, in_byte_ff};
      for (int k = 0; k < crc32rb_pkg::BYTE_WIDTH; k++) begin
         crc = crc[0] ? ((crc >> 1) ^ rpoly) : (crc >> 1);
      end
      crc_next = crc;
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      running_crc_in = running_crc_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in   = 1'b1;
         rsp_data_in    = crc_next ^ xor_out_ff;
         rsp_last_in    = in_last_ff;
         running_crc_in = crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff        <= crc32rb_pkg::POLY_RESET;
         init_ff        <= crc32rb_pkg::INIT_RESET;
         xor_out_ff     <= crc32rb_pkg::XOR_OUT_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         running_crc_ff <= '0;
      end else begin
         poly_ff        <= poly_in;
         init_ff        <= init_in;
         xor_out_ff     <= xor_out_in;
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         running_crc_ff <= running_crc_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_seed_ff  <= in_seed_in;
      in_first_ff <= in_first_in;
      in_last_ff  <= in_last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A request that leaves the input stage lands in the result register.
   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("request left the input stage but no result was registered");

   // A held request is never dropped while the result side is stalled.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("request lost from the input stage");

   // The result and the running CRC differ exactly by the xor-out value in use.
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((rsp_data_ff ^ running_crc_ff) == $past(xor_out_ff)))
      else $error("result does not match the running CRC");

endmodule
